>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  `ASSERT_HOLDS(lbl, clk, rstn, !(cond))

`endif

>>> rtl/ipv4hc_pkg.sv
package ipv4hc_pkg;

  localparam int CountWidthDef = 32;
  localparam int NumCats       = 8;
  localparam int CatW          = $clog2(NumCats);

  typedef enum logic [3:0] {
    V_SMALL    = 4'd0,
    V_VERSION  = 4'd1,
    V_HDRLEN   = 4'd2,
    V_CHECKSUM = 4'd3,
    V_TOTLEN   = 4'd4,
    V_SHORT    = 4'd5,
    V_FRAGMENT = 4'd6,
    V_TCP      = 4'd7,
    V_UDP      = 4'd8,
    V_ICMP     = 4'd9,
    V_OTHER    = 4'd10
  } verdict_e;

  // statistics slot shared by all delivered verdicts
  localparam logic [CatW-1:0] CatDelivered = CatW'(7);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic [5:0]  header_bytes;
    logic [15:0] payload_len;
    logic [7:0]  protocol;
    logic [31:0] category_count;
    logic [31:0] packet_count;
  } out_t;

  // verdict of one packet, handed from parser to statistics
  typedef struct packed {
    verdict_e        verdict;
    logic [CatW-1:0] cat;
    logic [5:0]      header_bytes;
    logic [15:0]     payload_len;
    logic [7:0]      protocol;
  } info_t;

  typedef struct packed {
    logic s1_valid;
    logic fwd_hit;
  } stats_status_t;

endpackage

>>> rtl/ipv4hc_stream_if.sv
interface ipv4hc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/ipv4hc_parser.sv
module ipv4hc_parser
  import ipv4hc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  in_t        byte_i,
  output info_t      info_o
);

  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;
  localparam logic [7:0] ProtoIcmp = 8'd1;

  logic [15:0] idx_q, idx_d;
  logic [16:0] acc_q, acc_d;
  logic [7:0]  hi_q, hi_d;
  logic [7:0]  vi_q, vi_d;
  logic [15:0] tl_q, tl_d;
  logic [15:0] fw_q, fw_d;
  logic [7:0]  pr_q, pr_d;
  logic [5:0]  hlen;
  logic [17:0] sum;
  logic [7:0]  b;
  verdict_e    verdict;
  logic        delivered;

  assign b = byte_i.data_byte;

  always_comb begin
    vi_d = vi_q;
    tl_d = tl_q;
    fw_d = fw_q;
    pr_d = pr_q;
    case (idx_q)
      16'd0:   vi_d = b;
      16'd2:   tl_d = {b, tl_q[7:0]};
      16'd3:   tl_d = {tl_q[15:8], b};
      16'd6:   fw_d = {b, fw_q[7:0]};
      16'd7:   fw_d = {fw_q[15:8], b};
      16'd9:   pr_d = b;
      default: ;
    endcase
  end

  assign hlen = {vi_d[3:0], 2'b00};
  assign sum  = {1'b0, acc_q} + {2'b00, hi_q, b};

  // header words feed the sum, odd bytes close a word
  always_comb begin
    acc_d = acc_q;
    hi_d  = hi_q;
    if (idx_q < {10'd0, hlen}) begin
      if (!idx_q[0]) begin
        hi_d = b;
      end else begin
        acc_d = {1'b0, sum[15:0]} + {15'd0, sum[17:16]};
      end
    end
  end

  assign idx_d = (idx_q != 16'hFFFF) ? idx_q + 16'd1 : idx_q;

  always_comb begin
    delivered = 1'b0;
    if (idx_d < 16'd20) begin
      verdict = V_SMALL;
    end else if (vi_d[7:4] != 4'd4) begin
      verdict = V_VERSION;
    end else if (hlen < 6'd20 || {10'd0, hlen} > idx_d) begin
      verdict = V_HDRLEN;
    end else if (acc_d != 17'h0FFFF) begin
      verdict = V_CHECKSUM;
    end else if (tl_d < {10'd0, hlen}) begin
      verdict = V_TOTLEN;
    end else if (idx_d < tl_d) begin
      verdict = V_SHORT;
    end else if ((fw_d & 16'hBFFF) != 16'd0) begin
      verdict = V_FRAGMENT;
    end else begin
      delivered = 1'b1;
      case (pr_d)
        ProtoTcp:  verdict = V_TCP;
        ProtoUdp:  verdict = V_UDP;
        ProtoIcmp: verdict = V_ICMP;
        default:   verdict = V_OTHER;
      endcase
    end
  end

  assign info_o.verdict      = verdict;
  assign info_o.cat          = delivered ? CatDelivered : verdict[CatW-1:0];
  assign info_o.header_bytes = hlen;
  assign info_o.payload_len  = delivered ? tl_d - {10'd0, hlen} : 16'd0;
  assign info_o.protocol     = pr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      acc_q <= '0;
      hi_q  <= '0;
      vi_q  <= '0;
      tl_q  <= '0;
      fw_q  <= '0;
      pr_q  <= '0;
    end else if (take_i) begin
      if (byte_i.last_byte) begin
        idx_q <= '0;
        acc_q <= '0;
        hi_q  <= '0;
        vi_q  <= '0;
        tl_q  <= '0;
        fw_q  <= '0;
        pr_q  <= '0;
      end else begin
        idx_q <= idx_d;
        acc_q <= acc_d;
        hi_q  <= hi_d;
        vi_q  <= vi_d;
        tl_q  <= tl_d;
        fw_q  <= fw_d;
        pr_q  <= pr_d;
      end
    end
  end

endmodule

>>> rtl/ipv4hc_stats.sv
module ipv4hc_stats
  import ipv4hc_pkg::*;
#(
  parameter int CountWidth = CountWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  info_t         info_i,
  output logic          can_take_o,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output out_t          res_o,
  output stats_status_t status_o
);

  logic [CountWidth-1:0] cnt_mem [NumCats];
  logic [NumCats-1:0]    cnt_vld_q;
  logic [CountWidth-1:0] rd_data_q;
  logic                  rd_vld_q;

  logic                  s1_valid_q;
  info_t                 s1_info_q;
  logic                  s1_adv;

  logic                  fwd_valid_q;
  logic [CatW-1:0]       fwd_addr_q;
  logic [CountWidth-1:0] fwd_data_q;
  logic                  fwd_hit;

  logic [CountWidth-1:0] total_q;
  logic [CountWidth-1:0] cur, cat_new, tot_new;
  logic [31:0]           cat_rep, tot_rep;

  logic                  out_valid_q;
  out_t                  out_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || res_ready_i);
  assign can_take_o = !s1_valid_q || s1_adv;

  // last write may not yet be visible in the read data
  assign fwd_hit = fwd_valid_q && (fwd_addr_q == s1_info_q.cat);
  assign cur     = fwd_hit ? fwd_data_q : (rd_vld_q ? rd_data_q : '0);
  assign cat_new = (&cur) ? cur : cur + CountWidth'(1);
  assign tot_new = (&total_q) ? total_q : total_q + CountWidth'(1);

  generate
    if (CountWidth > 32) begin : g_clip
      assign cat_rep = (|cat_new[CountWidth-1:32]) ? 32'hFFFF_FFFF : cat_new[31:0];
      assign tot_rep = (|tot_new[CountWidth-1:32]) ? 32'hFFFF_FFFF : tot_new[31:0];
    end else if (CountWidth == 32) begin : g_same
      assign cat_rep = cat_new;
      assign tot_rep = tot_new;
    end else begin : g_ext
      assign cat_rep = {{(32-CountWidth){1'b0}}, cat_new};
      assign tot_rep = {{(32-CountWidth){1'b0}}, tot_new};
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      cnt_mem[s1_info_q.cat] <= cat_new;
    end
    if (take_i) begin
      rd_data_q <= cnt_mem[info_i.cat];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_i) begin
        rd_vld_q <= cnt_vld_q[info_i.cat];
      end
      if (s1_adv) begin
        cnt_vld_q[s1_info_q.cat] <= 1'b1;
        fwd_valid_q              <= 1'b1;
        total_q                  <= tot_new;
      end
      if (can_take_o) begin
        s1_valid_q <= take_i;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      s1_info_q <= info_i;
    end
    if (s1_adv) begin
      fwd_addr_q           <= s1_info_q.cat;
      fwd_data_q           <= cat_new;
      out_q.verdict        <= s1_info_q.verdict;
      out_q.header_bytes   <= s1_info_q.header_bytes;
      out_q.payload_len    <= s1_info_q.payload_len;
      out_q.protocol       <= s1_info_q.protocol;
      out_q.category_count <= cat_rep;
      out_q.packet_count   <= tot_rep;
    end
  end

  assign res_valid_o       = out_valid_q;
  assign res_o             = out_q;
  assign status_o.s1_valid = s1_valid_q;
  assign status_o.fwd_hit  = fwd_hit;

endmodule

>>> rtl/ipv4_header_check_classify.sv
// IPv4 receive header check and classifier. Takes one packet byte per request
// with a last-byte mark, at a sustained rate of one byte per clock, also when
// every byte closes a packet. Header fields and the ones-complement header sum
// are built in registers as bytes pass; the verdict is formed on the last byte
// and registered in the verdict stage, and its result request is registered
// after the read-modify-write of the statistics counter memory (one synchronous
// read, one write a cycle, with the latest write forwarded). Counters are
// COUNT_WIDTH bits, saturate at all ones and are reported clipped to 32 bits;
// they start from zero after reset with no clearing pass. A stalled result holds
// the input off once the verdict stage behind it is also full.
`include "assert_macros.svh"

module ipv4_header_check_classify
  import ipv4hc_pkg::*;
#(
  parameter int COUNT_WIDTH = CountWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ipv4hc_stream_if.sink   pkt_i,
  ipv4hc_stream_if.source res_o
);

  logic          take;
  logic          take_last;
  logic          can_take;
  info_t         info;
  stats_status_t st;
  out_t          res;

  // non-final bytes only update the parser; the final byte also books a verdict
  assign pkt_i.ready = can_take;
  assign take        = pkt_i.valid && can_take;
  assign take_last   = take && pkt_i.data.last_byte;

  ipv4hc_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (pkt_i.data),
    .info_o (info)
  );

  // counter memory and result register
  ipv4hc_stats #(
    .CountWidth (COUNT_WIDTH)
  ) u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take_last),
    .info_i      (info),
    .can_take_o  (can_take),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_o       (res),
    .status_o    (st)
  );

  assign res_o.data = res;

  // a final byte always lands in the verdict stage
  `ASSERT_HOLDS(a_last_books, clk_i, rst_ni, take_last |=> st.s1_valid)
  // input only backs up behind a stalled result with the verdict stage full
  `ASSERT_HOLDS(a_ready_stall, clk_i, rst_ni,
                !pkt_i.ready |-> (st.s1_valid && res_o.valid && !res_o.ready))
  // total counter never trails a category counter
  `ASSERT_NEVER(a_count_order, clk_i, rst_ni,
                res_o.valid && (res.packet_count < res.category_count))
  // header length is a whole number of words
  `ASSERT_NEVER(a_hdr_words, clk_i, rst_ni,
                res_o.valid && (res.header_bytes[1:0] != 2'b00))

endmodule
